// ===== rtl/point_rotate_recenter_macros.svh =====
// Assertion macros for the RTL file that checks its own logic.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef POINT_ROTATE_RECENTER_MACROS_SVH
`define POINT_ROTATE_RECENTER_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define PRR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define PRR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/prr_pkg.sv =====
`default_nettype none

package prr_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_JOINTS     = 32;
    localparam int DEF_COEF_FRAC_BITS = 14;

    // Fixed field widths.
    localparam int POS_W  = 16;
    localparam int ROT_W  = 18;
    localparam int JIDX_W = 5;

    // Starting value of the running Z minimum.
    localparam logic signed [ROT_W-1:0] MIN_Z_INIT = ROT_W'(9999);

    // Saturation bounds for the 16-bit outputs.
    localparam logic signed [ROT_W:0] SAT_HI = (ROT_W+1)'(32767);
    localparam logic signed [ROT_W:0] SAT_LO = -(ROT_W+1)'(32768);

    // One rotated point, also the word kept in the frame buffer.
    typedef struct packed {
        logic signed [ROT_W-1:0] rx;
        logic signed [ROT_W-1:0] ry;
        logic signed [ROT_W-1:0] rz;
    } point_t;

    // Steps of the rotation sequencer.
    typedef enum logic [2:0] {
        ROT_MUL_SY,
        ROT_MUL_CZ,
        ROT_MUL_CY,
        ROT_MUL_SZ,
        ROT_ACC_LAST,
        ROT_ROUND
    } rot_step_t;

    // Top-level control states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROT,
        ST_OUT,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_RD,
        ST_EMIT
    } prr_state_t;

    // Adds a rotated value and a shift, then clamps to the signed 16-bit range.
    function automatic logic signed [POS_W-1:0] add_sat(input logic signed [ROT_W-1:0] a,
                                                        input logic signed [ROT_W-1:0] b);
        logic signed [ROT_W:0] s;
        logic signed [POS_W-1:0] r;
        s = {a[ROT_W-1], a} + {b[ROT_W-1], b};
        if (s > SAT_HI)
        begin
            r = SAT_HI[POS_W-1:0];
        end
        else if (s < SAT_LO)
        begin
            r = SAT_LO[POS_W-1:0];
        end
        else
        begin
            r = s[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/prr_in_if.sv =====
`default_nettype none

interface prr_in_if import prr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  pos_z;
    logic              frame_end;

    modport source (output valid, output pos_x, output pos_y, output pos_z,
                    output frame_end, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                    input frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/prr_out_if.sv =====
`default_nettype none

interface prr_out_if import prr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  out_x;
    logic [POS_W-1:0]  out_y;
    logic [POS_W-1:0]  out_z;
    logic [JIDX_W-1:0] joint_index;
    logic              last_out;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output joint_index, output last_out, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input joint_index, input last_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/prr_ram.sv =====
`default_nettype none

module prr_ram #(
    parameter int WIDTH = 54,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/prr_rot.sv =====
`default_nettype none

module prr_rot import prr_pkg::*; #(
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [POS_W-1:0] x,
    input  wire logic signed [POS_W-1:0] y,
    input  wire logic signed [POS_W-1:0] z,
    output logic                         done,
    output point_t                       res
);

    localparam int COEF_W = COEF_FRAC_BITS + 2;
    localparam int PROD_W = POS_W + COEF_W;
    localparam int ACC_W  = PROD_W + 1;

    localparam logic [63:0] S_VAL = ((64'd1736 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic [63:0] C_VAL = ((64'd9848 << COEF_FRAC_BITS) + 64'd5000) / 64'd10000;
    localparam logic signed [COEF_W-1:0] COEF_S = S_VAL[COEF_W-1:0];
    localparam logic signed [COEF_W-1:0] COEF_C = C_VAL[COEF_W-1:0];
    localparam logic signed [ACC_W-1:0]  HALF   = ACC_W'(1) << (COEF_FRAC_BITS - 1);

    rot_step_t                step_reg, step_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic signed [POS_W-1:0]  y_reg, y_next;
    logic signed [POS_W-1:0]  z_reg, z_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     neg_reg, neg_next;
    logic signed [ACC_W-1:0]  acc_y_reg, acc_y_next;
    logic signed [ACC_W-1:0]  acc_z_reg, acc_z_next;
    point_t                   res_reg, res_next;

    logic signed [POS_W-1:0]  op_a;
    logic signed [COEF_W-1:0] op_c;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  round_y;
    logic signed [ACC_W-1:0]  round_z;

    always_comb
    begin
        step_next  = step_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        y_next     = y_reg;
        z_next     = z_reg;
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        acc_y_next = acc_y_reg;
        acc_z_next = acc_z_reg;
        res_next   = res_reg;
        op_a       = y_reg;
        op_c       = COEF_S;

        // The product of the previous step is registered before it enters the accumulators.
        term = {prod_reg[PROD_W-1], prod_reg};
        if (neg_reg)
        begin
            term = -term;
        end
        round_y = (acc_y_reg + HALF) >>> COEF_FRAC_BITS;
        round_z = (acc_z_reg + HALF) >>> COEF_FRAC_BITS;

        case (step_reg)
            ROT_MUL_SY:
            begin
                op_a = y_reg;
                op_c = COEF_S;
            end
            ROT_MUL_CZ:
            begin
                op_a = z_reg;
                op_c = COEF_C;
            end
            ROT_MUL_CY:
            begin
                op_a = y_reg;
                op_c = COEF_C;
            end
            ROT_MUL_SZ:
            begin
                op_a = z_reg;
                op_c = COEF_S;
            end
            default:
            begin
                op_a = y_reg;
                op_c = COEF_S;
            end
        endcase

        if (start)
        begin
            y_next    = y;
            z_next    = z;
            res_next.rx = {{(ROT_W-POS_W){x[POS_W-1]}}, x};
            step_next = ROT_MUL_SY;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            prod_next = op_a * op_c;
            case (step_reg)
                ROT_MUL_SY:
                begin
                    neg_next  = 1'b1;
                    step_next = ROT_MUL_CZ;
                end
                ROT_MUL_CZ:
                begin
                    acc_y_next = term;
                    neg_next   = 1'b0;
                    step_next  = ROT_MUL_CY;
                end
                ROT_MUL_CY:
                begin
                    acc_y_next = acc_y_reg + term;
                    neg_next   = 1'b1;
                    step_next  = ROT_MUL_SZ;
                end
                ROT_MUL_SZ:
                begin
                    acc_z_next = term;
                    neg_next   = 1'b1;
                    step_next  = ROT_ACC_LAST;
                end
                ROT_ACC_LAST:
                begin
                    acc_z_next = acc_z_reg + term;
                    step_next  = ROT_ROUND;
                end
                ROT_ROUND:
                begin
                    res_next.ry = round_y[ROT_W-1:0];
                    res_next.rz = round_z[ROT_W-1:0];
                    done_next   = 1'b1;
                    busy_next   = 1'b0;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ROT_MUL_SY;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg     <= y_next;
        z_reg     <= z_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        acc_y_reg <= acc_y_next;
        acc_z_reg <= acc_z_next;
        res_reg   <= res_next;
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

// ===== rtl/prr_div.sv =====
`default_nettype none

module prr_div import prr_pkg::*; #(
    parameter int DVD_W = 24,
    parameter int DVS_W = 6
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [DVD_W-1:0] dividend,
    input  wire logic        [DVS_W-1:0] divisor,
    output logic                         done,
    output logic signed [DVD_W-1:0]      quotient
);

    // Restoring division on the magnitude, one quotient bit per cycle.
    localparam int ITER_W = $clog2(DVD_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic [DVD_W-1:0]  mag_reg, mag_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic              neg_reg, neg_next;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              fits;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        iter_next = iter_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;

        trial = {rem_reg, mag_reg[DVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        fits  = (trial >= {1'b0, dvs_reg});

        if (start)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            neg_next  = dividend[DVD_W-1];
            mag_next  = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            mag_next = {mag_reg[DVD_W-2:0], fits};
            iter_next = iter_reg + ITER_W'(1);
            if (iter_reg == ITER_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

endmodule

`default_nettype wire

// ===== rtl/point_rotate_recenter.sv =====
// Channel  Dir  Contents
// in_ch    in   pos_x, pos_y, pos_z (signed mm), frame_end
// out_ch   out  out_x, out_y, out_z (signed mm, saturated), joint_index, last_out
//
// While streaming, a point is accepted only after the previous one has left ST_OUT; the
// rotation sequencer does its four multiplies through one shared multiplier.
// In the first frame each point is stored in the buffer; after its last point two serial
// divisions run in turn, then each stored word leaves through a buffer read.
// Reset is asynchronous and clears all control state; the frame buffer needs no clear.
// A stalled output holds its register; the next point is accepted meanwhile.
`default_nettype none

`include "point_rotate_recenter_macros.svh"

module point_rotate_recenter import prr_pkg::*; #(
    parameter int MAX_JOINTS     = DEF_MAX_JOINTS,
    parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
    input  wire logic clk,
    input  wire logic rst_n,
    prr_in_if.sink    in_ch,
    prr_out_if.source out_ch
);

    // Buffer addressing and the count of stored points, which can reach MAX_JOINTS.
    localparam int ADDR_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_JOINTS + 1);
    // Sums of up to MAX_JOINTS rotated values.
    localparam int SUM_W  = ROT_W + CNT_W;

    prr_state_t              state_reg, state_next;
    logic                    shift_ready_reg, shift_ready_next;
    logic signed [ROT_W-1:0] shift_x_reg, shift_x_next;
    logic signed [ROT_W-1:0] shift_y_reg, shift_y_next;
    logic signed [ROT_W-1:0] shift_z_reg, shift_z_next;
    logic signed [SUM_W-1:0] sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0] sum_y_reg, sum_y_next;
    logic signed [ROT_W-1:0] min_z_reg, min_z_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [JIDX_W-1:0]       stream_pos_reg, stream_pos_next;
    logic [ADDR_W-1:0]       emit_idx_reg, emit_idx_next;
    logic                    fend_reg, fend_next;

    logic                    out_valid_reg, out_valid_next;
    logic [POS_W-1:0]        out_x_reg, out_x_next;
    logic [POS_W-1:0]        out_y_reg, out_y_next;
    logic [POS_W-1:0]        out_z_reg, out_z_next;
    logic [JIDX_W-1:0]       out_idx_reg, out_idx_next;
    logic                    out_last_reg, out_last_next;

    logic                    in_accept;
    logic                    out_free;
    logic                    rot_done;
    point_t                  rot_res;
    logic                    ram_we;
    logic [$bits(point_t)-1:0] ram_rdata;
    point_t                  rd_point;
    logic                    div_start;
    logic signed [SUM_W-1:0] div_dividend;
    logic                    div_done;
    logic signed [SUM_W-1:0] div_quot;
    logic signed [SUM_W-1:0] neg_quot;
    logic [ADDR_W+JIDX_W-1:0] idx_ext;
    logic                    emit_last;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    // Rotation about X through the shared multiplier.
    prr_rot #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_rot (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_accept),
        .x     (signed'(in_ch.pos_x)),
        .y     (signed'(in_ch.pos_y)),
        .z     (signed'(in_ch.pos_z)),
        .done  (rot_done),
        .res   (rot_res)
    );

    // The first frame waits here until its shift is known.
    prr_ram #(
        .WIDTH ($bits(point_t)),
        .DEPTH (MAX_JOINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (rot_res),
        .raddr (emit_idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_point = point_t'(ram_rdata);

    // One serial divider computes both means in turn.
    prr_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign div_start    = (state_reg == ST_DIVX_GO) || (state_reg == ST_DIVY_GO);
    assign div_dividend = (state_reg == ST_DIVX_GO) ? sum_x_reg : sum_y_reg;
    assign neg_quot     = -div_quot;
    assign idx_ext      = {{JIDX_W{1'b0}}, emit_idx_reg};
    assign emit_last    = (CNT_W'(emit_idx_reg) + CNT_W'(1)) == cnt_reg;

    always_comb
    begin
        state_next       = state_reg;
        shift_ready_next = shift_ready_reg;
        shift_x_next     = shift_x_reg;
        shift_y_next     = shift_y_reg;
        shift_z_next     = shift_z_reg;
        sum_x_next       = sum_x_reg;
        sum_y_next       = sum_y_reg;
        min_z_next       = min_z_reg;
        cnt_next         = cnt_reg;
        stream_pos_next  = stream_pos_reg;
        emit_idx_next    = emit_idx_reg;
        fend_next        = fend_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_z_next       = out_z_reg;
        out_idx_next     = out_idx_reg;
        out_last_next    = out_last_reg;
        ram_we           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    fend_next  = in_ch.frame_end;
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                if (rot_done)
                begin
                    if (shift_ready_reg)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        // Points beyond the buffer are dropped but may still close the frame.
                        if (cnt_reg < CNT_W'(MAX_JOINTS))
                        begin
                            ram_we     = 1'b1;
                            sum_x_next = sum_x_reg + {{(SUM_W-ROT_W){rot_res.rx[ROT_W-1]}},
                                                      rot_res.rx};
                            sum_y_next = sum_y_reg + {{(SUM_W-ROT_W){rot_res.ry[ROT_W-1]}},
                                                      rot_res.ry};
                            if (rot_res.rz < min_z_reg)
                            begin
                                min_z_next = rot_res.rz;
                            end
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                        state_next = fend_reg ? ST_DIVX_GO : ST_IDLE;
                    end
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_x_next      = add_sat(rot_res.rx, shift_x_reg);
                    out_y_next      = add_sat(rot_res.ry, shift_y_reg);
                    out_z_next      = add_sat(rot_res.rz, shift_z_reg);
                    out_idx_next    = stream_pos_reg;
                    out_last_next   = fend_reg;
                    stream_pos_next = fend_reg ? '0 : stream_pos_reg + JIDX_W'(1);
                    state_next      = ST_IDLE;
                end
            end
            ST_DIVX_GO:
            begin
                state_next = ST_DIVX_WAIT;
            end
            ST_DIVX_WAIT:
            begin
                if (div_done)
                begin
                    shift_x_next = neg_quot[ROT_W-1:0];
                    state_next   = ST_DIVY_GO;
                end
            end
            ST_DIVY_GO:
            begin
                state_next = ST_DIVY_WAIT;
            end
            ST_DIVY_WAIT:
            begin
                if (div_done)
                begin
                    shift_y_next  = neg_quot[ROT_W-1:0];
                    shift_z_next  = -min_z_reg;
                    emit_idx_next = '0;
                    state_next    = ST_RD;
                end
            end
            ST_RD:
            begin
                // The buffer read address is stable from here, so its data is ready next.
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = add_sat(rd_point.rx, shift_x_reg);
                    out_y_next     = add_sat(rd_point.ry, shift_y_reg);
                    out_z_next     = add_sat(rd_point.rz, shift_z_reg);
                    out_idx_next   = idx_ext[JIDX_W-1:0];
                    out_last_next  = emit_last;
                    if (emit_last)
                    begin
                        shift_ready_next = 1'b1;
                        sum_x_next       = '0;
                        sum_y_next       = '0;
                        min_z_next       = MIN_Z_INIT;
                        cnt_next         = '0;
                        stream_pos_next  = '0;
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + ADDR_W'(1);
                        state_next    = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            shift_ready_reg <= 1'b0;
            shift_x_reg     <= '0;
            shift_y_reg     <= '0;
            shift_z_reg     <= '0;
            sum_x_reg       <= '0;
            sum_y_reg       <= '0;
            min_z_reg       <= MIN_Z_INIT;
            cnt_reg         <= '0;
            stream_pos_reg  <= '0;
            emit_idx_reg    <= '0;
            fend_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            shift_ready_reg <= shift_ready_next;
            shift_x_reg     <= shift_x_next;
            shift_y_reg     <= shift_y_next;
            shift_z_reg     <= shift_z_next;
            sum_x_reg       <= sum_x_next;
            sum_y_reg       <= sum_y_next;
            min_z_reg       <= min_z_next;
            cnt_reg         <= cnt_next;
            stream_pos_reg  <= stream_pos_next;
            emit_idx_reg    <= emit_idx_next;
            fend_reg        <= fend_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_z_reg    <= out_z_next;
        out_idx_reg  <= out_idx_next;
        out_last_reg <= out_last_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_x       = out_x_reg;
    assign out_ch.out_y       = out_y_reg;
    assign out_ch.out_z       = out_z_reg;
    assign out_ch.joint_index = out_idx_reg;
    assign out_ch.last_out    = out_last_reg;

    // Once the shift is known it stays known until reset.
    `PRR_ASSERT_NXT(a_shift_sticky, shift_ready_reg, shift_ready_reg, "shift ready dropped")
    // Streaming never leaves points in the buffer.
    `PRR_ASSERT_IMP(a_stream_empty, shift_ready_reg, cnt_reg == '0, "buffer count not empty")
    // The buffer count never passes the buffer depth.
    `PRR_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(MAX_JOINTS), "buffer count overflow")
    // An accepted word always starts the rotation sequence.
    `PRR_ASSERT_NXT(a_accept_rot, in_accept, state_reg == ST_ROT, "accept without rotation")

endmodule

`default_nettype wire
